// ===== rtl/core/tpr_pkg.sv =====
// Shared constants, types and the sine table builder for the torus point renderer.
package tpr_pkg;

  localparam int ANGLE_BITS = 12;
  localparam int FRAC_BITS  = 12;
  localparam int QUARTER    = 1 << (ANGLE_BITS - 2);

  // Trig values lie in [-1, 1] with FRAC_BITS fraction bits.
  localparam int LUT_W  = FRAC_BITS + 1;
  localparam int TRIG_W = FRAC_BITS + 2;

  localparam int RAD_W   = 15;
  localparam int VD_W    = 16;
  localparam int XY_W    = FRAC_BITS + 6;
  localparam int X2_W    = FRAC_BITS + 7;
  localparam int NRM_W   = FRAC_BITS + 3;
  localparam int NSQ_W   = 2 * (FRAC_BITS + 2);
  localparam int NUM_W   = FRAC_BITS + 14;
  localparam int DMAG_W  = X2_W - 1;
  localparam int Q_BITS  = 9;
  localparam int SCR_W   = 9;
  localparam int CELL_W  = 8;
  localparam int SHADE_W = 4;
  localparam int CFG_W   = 16;

  typedef enum logic [2:0] {
    REG_ANGLE_A,
    REG_ANGLE_B,
    REG_MAJOR_RADIUS,
    REG_MINOR_RADIUS,
    REG_VIEW_DISTANCE,
    REG_SCREEN_COLS,
    REG_SCREEN_ROWS
  } cfg_reg_e;

  typedef logic [LUT_W-1:0] lut_t [QUARTER+1];

  // Quarter-wave sine, 11th-order Taylor series in Q30, rounded to FRAC_BITS.
  function automatic lut_t build_sine_lut();
    lut_t tbl;
    longint unsigned x, x2, t, s, v;
    for (int r = 0; r <= QUARTER; r++) begin
      x  = (longint'(r) * 64'd1686629713) >> (ANGLE_BITS - 2);
      x2 = (x * x) >> 30;
      t  = 64'd1 << 30;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 110;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 72;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      v  = (s + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
      tbl[r] = LUT_W'(v);
    end
    return tbl;
  endfunction

endpackage

// ===== rtl/core/tpr_trig_rom.sv =====
// Registered sine lookup over a folded quarter-wave table.
module tpr_trig_rom (
  input  logic                                clk_i,
  input  logic [tpr_pkg::ANGLE_BITS-1:0]      angle_i,
  output logic signed [tpr_pkg::TRIG_W-1:0]   sine_o
);

  localparam int A = tpr_pkg::ANGLE_BITS;
  localparam tpr_pkg::lut_t Lut = tpr_pkg::build_sine_lut();

  logic [1:0]                       quad;
  logic [A-3:0]                     rem;
  logic [A-2:0]                     idx;
  logic signed [tpr_pkg::TRIG_W-1:0] sine_d, sine_q;

  assign quad = angle_i[A-1:A-2];
  assign rem  = angle_i[A-3:0];
  // Odd quadrants run the table backwards.
  assign idx  = quad[0] ? ((A-1)'(tpr_pkg::QUARTER) - {1'b0, rem}) : {1'b0, rem};

  always_comb begin
    sine_d = $signed({1'b0, Lut[idx]});
    if (quad[1]) begin
      sine_d = -sine_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sine_q <= sine_d;
  end

  assign sine_o = sine_q;

endmodule

// ===== rtl/core/tpr_geom.sv =====
// Four-stage geometry pipeline: torus point, two rotations, depth and shade.
module tpr_geom (
  input  logic                                 clk_i,
  input  logic signed [tpr_pkg::TRIG_W-1:0]    ct_i,
  input  logic signed [tpr_pkg::TRIG_W-1:0]    st_i,
  input  logic signed [tpr_pkg::TRIG_W-1:0]    cp_i,
  input  logic signed [tpr_pkg::TRIG_W-1:0]    sp_i,
  input  logic signed [tpr_pkg::TRIG_W-1:0]    ca_i,
  input  logic signed [tpr_pkg::TRIG_W-1:0]    sa_i,
  input  logic signed [tpr_pkg::TRIG_W-1:0]    cb_i,
  input  logic signed [tpr_pkg::TRIG_W-1:0]    sb_i,
  input  logic [tpr_pkg::RAD_W-1:0]            major_i,
  input  logic [tpr_pkg::RAD_W-1:0]            minor_i,
  input  logic [tpr_pkg::VD_W-1:0]             vd_i,
  output logic signed [tpr_pkg::X2_W-1:0]      x2_o,
  output logic signed [tpr_pkg::X2_W-1:0]      y2_o,
  output logic signed [tpr_pkg::X2_W-1:0]      d_o,
  output logic [tpr_pkg::SHADE_W-1:0]          shade_o
);

  localparam int F  = tpr_pkg::FRAC_BITS;
  localparam int TW = tpr_pkg::TRIG_W;
  localparam int XW = tpr_pkg::XY_W;
  localparam int VW = tpr_pkg::X2_W;
  localparam int NW = tpr_pkg::NRM_W;
  localparam int SW = tpr_pkg::NSQ_W;
  localparam int PW = XW + TW;
  localparam int RW = tpr_pkg::RAD_W + 1 + TW;
  localparam int NSHADE = 11;

  // Stage 2
  logic signed [XW-1:0] w_d, w_q, z_d, z_q;
  logic signed [NW-1:0] n_d, n_q;
  logic signed [TW-1:0] cp_q, sp_q;
  // Stage 3
  logic signed [XW-1:0] x_d, x_q, y_d, y_q, z3_q;
  logic [SW-1:0]        nsq_d, nsq_q;
  // Stage 4
  logic signed [XW-1:0] y1_d, y1_q, z1_d, z1_q, x4_q;
  logic [tpr_pkg::SHADE_W-1:0] shade_d, shade4_q, shade5_q;
  logic [NSHADE-1:0]    ge;
  // Stage 5
  logic signed [VW-1:0] x2_d, x2_q, y2_d, y2_q, d_d, d_q;

  always_comb begin
    logic signed [RW-1:0] mc, ms;
    logic signed [2*TW-1:0] cs;
    mc  = $signed({1'b0, minor_i}) * ct_i;
    ms  = $signed({1'b0, minor_i}) * st_i;
    cs  = ct_i * sp_i;
    w_d = XW'($signed({1'b0, major_i})) + XW'(mc >>> F);
    z_d = XW'(ms >>> F);
    n_d = NW'(cs >>> F) - NW'(st_i);
  end

  always_comb begin
    logic signed [PW-1:0] px, py;
    logic [NW-2:0] nm;
    px    = w_q * cp_q;
    py    = w_q * sp_q;
    x_d   = XW'(px >>> F);
    y_d   = XW'(py >>> F);
    nm    = n_q[NW-2:0];
    nsq_d = (n_q > 0) ? SW'(nm * nm) : '0;
  end

  always_comb begin
    logic signed [PW-1:0] p0, p1, p2, p3;
    p0   = y_q * ca_i;
    p1   = z3_q * sa_i;
    p2   = y_q * sa_i;
    p3   = z3_q * ca_i;
    y1_d = XW'(p0 >>> F) - XW'(p1 >>> F);
    z1_d = XW'(p2 >>> F) + XW'(p3 >>> F);
  end

  // Shade k holds when 121 n^2 >= 2 k^2 (2^F)^2.
  for (genvar k = 1; k <= NSHADE; k++) begin : g_thr
    localparam longint unsigned Thr =
      ((64'd2 * k * k) * (64'd1 << (2 * F)) + 64'd120) / 64'd121;
    assign ge[k-1] = ({1'b0, nsq_q} >= (SW+1)'(Thr));
  end

  always_comb begin
    shade_d = '0;
    for (int i = 0; i < NSHADE; i++) begin
      if (ge[i]) begin
        shade_d = tpr_pkg::SHADE_W'(i + 1);
      end
    end
  end

  always_comb begin
    logic signed [PW-1:0] q0, q1, q2, q3;
    q0   = x4_q * cb_i;
    q1   = y1_q * sb_i;
    q2   = x4_q * sb_i;
    q3   = y1_q * cb_i;
    x2_d = VW'(q0 >>> F) - VW'(q1 >>> F);
    y2_d = VW'(q2 >>> F) + VW'(q3 >>> F);
    d_d  = VW'(z1_q) + VW'($signed({1'b0, vd_i}));
  end

  always_ff @(posedge clk_i) begin
    w_q      <= w_d;
    z_q      <= z_d;
    n_q      <= n_d;
    cp_q     <= cp_i;
    sp_q     <= sp_i;
    x_q      <= x_d;
    y_q      <= y_d;
    z3_q     <= z_q;
    nsq_q    <= nsq_d;
    y1_q     <= y1_d;
    z1_q     <= z1_d;
    x4_q     <= x_q;
    shade4_q <= shade_d;
    x2_q     <= x2_d;
    y2_q     <= y2_d;
    d_q      <= d_d;
    shade5_q <= shade4_q;
  end

  assign x2_o    = x2_q;
  assign y2_o    = y2_q;
  assign d_o     = d_q;
  assign shade_o = shade5_q;

endmodule

// ===== rtl/core/tpr_div.sv =====
// Pipelined restoring divider: magnitude and range check, then three quotient bits per stage.
module tpr_div (
  input  logic                                clk_i,
  input  logic signed [tpr_pkg::NUM_W-1:0]    num_i,
  input  logic [tpr_pkg::DMAG_W-1:0]          den_i,
  output logic [tpr_pkg::Q_BITS-1:0]          quot_o,
  output logic                                big_o,
  output logic                                neg_o
);

  localparam int QB    = tpr_pkg::Q_BITS;
  localparam int REM_W = tpr_pkg::NUM_W - 1;
  localparam int DW    = tpr_pkg::DMAG_W;
  localparam int SH_W  = DW + QB;
  localparam int STEPS = 3;
  localparam int NST   = QB / STEPS;

  logic [REM_W-1:0] rem_q  [NST+1];
  logic [DW-1:0]    den_q  [NST+1];
  logic [QB-1:0]    quot_q [NST+1];
  logic             big_q  [NST+1];
  logic             neg_q  [NST+1];

  logic [tpr_pkg::NUM_W-1:0] mag;

  assign mag = num_i[tpr_pkg::NUM_W-1] ? tpr_pkg::NUM_W'(-num_i) : tpr_pkg::NUM_W'(num_i);

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= mag[REM_W-1:0];
    den_q[0]  <= den_i;
    quot_q[0] <= '0;
    // A quotient of 2^QB or more can never land on the screen.
    big_q[0]  <= (SH_W'(mag[REM_W-1:0]) >= {den_i, {QB{1'b0}}});
    neg_q[0]  <= num_i[tpr_pkg::NUM_W-1];
  end

  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic [REM_W-1:0] rem_d;
    logic [QB-1:0]    quot_d;

    always_comb begin
      logic [SH_W-1:0] sh;
      rem_d  = rem_q[s];
      quot_d = quot_q[s];
      for (int j = 0; j < STEPS; j++) begin
        sh = SH_W'(den_q[s]) << (QB - 1 - STEPS * s - j);
        if (SH_W'(rem_d) >= sh) begin
          rem_d = rem_d - REM_W'(sh);
          quot_d[QB-1-STEPS*s-j] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s+1]  <= rem_d;
      den_q[s+1]  <= den_q[s];
      quot_q[s+1] <= quot_d;
      big_q[s+1]  <= big_q[s];
      neg_q[s+1]  <= neg_q[s];
    end
  end

  assign quot_o = quot_q[NST];
  assign big_o  = big_q[NST];
  assign neg_o  = neg_q[NST];

endmodule

// ===== rtl/core/torus_point_render.sv =====
// Top level of the torus point renderer: configuration, trig lookups, projection and output.
// done_o is high in the same cycle as its item's result stands on the outputs.
// Throughput: one item per cycle; busy_o stays low and every stage advances each cycle.
// The depth is set by the table lookup, four geometry stages, a numerator stage, a four-stage divider and the output register.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset clears the valid pipeline and returns the configuration registers to their defaults; datapath registers are not reset.
module torus_point_render (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [tpr_pkg::ANGLE_BITS-1:0]       theta_angle_i,
  input  logic [tpr_pkg::ANGLE_BITS-1:0]       phi_angle_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [2:0]                           cfg_index_i,
  input  logic [tpr_pkg::CFG_W-1:0]            cfg_data_i,
  output logic                                 done_o,
  output logic [tpr_pkg::CELL_W-1:0]           cell_x_o,
  output logic [tpr_pkg::CELL_W-1:0]           cell_y_o,
  output logic [tpr_pkg::SHADE_W-1:0]          shade_index_o,
  output logic                                 on_screen_o
);

  localparam int A    = tpr_pkg::ANGLE_BITS;
  localparam int TW   = tpr_pkg::TRIG_W;
  localparam int VW   = tpr_pkg::X2_W;
  localparam int NUMW = tpr_pkg::NUM_W;
  localparam int SCW  = tpr_pkg::SCR_W;
  localparam int LAT  = 11;
  localparam int SIDE = 4;

  // Configuration registers
  logic [A-1:0]                 angle_a_q, angle_b_q;
  logic [tpr_pkg::RAD_W-1:0]    major_q, minor_q;
  logic [tpr_pkg::VD_W-1:0]     vd_q;
  logic [SCW-1:0]               cols_q, rows_q, cols_c, rows_c;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_a_q <= '0;
      angle_b_q <= '0;
      major_q   <= tpr_pkg::RAD_W'(8192);
      minor_q   <= tpr_pkg::RAD_W'(4096);
      vd_q      <= tpr_pkg::VD_W'(20480);
      cols_q    <= SCW'(80);
      rows_q    <= SCW'(22);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (tpr_pkg::cfg_reg_e'(cfg_index_i))
        tpr_pkg::REG_ANGLE_A:       angle_a_q <= cfg_data_i[A-1:0];
        tpr_pkg::REG_ANGLE_B:       angle_b_q <= cfg_data_i[A-1:0];
        tpr_pkg::REG_MAJOR_RADIUS:  major_q   <= cfg_data_i[tpr_pkg::RAD_W-1:0];
        tpr_pkg::REG_MINOR_RADIUS:  minor_q   <= cfg_data_i[tpr_pkg::RAD_W-1:0];
        tpr_pkg::REG_VIEW_DISTANCE: vd_q      <= cfg_data_i[tpr_pkg::VD_W-1:0];
        tpr_pkg::REG_SCREEN_COLS:   cols_q    <= cfg_data_i[SCW-1:0];
        tpr_pkg::REG_SCREEN_ROWS:   rows_q    <= cfg_data_i[SCW-1:0];
        default: ;
      endcase
    end
  end

  // Screen sizes above 256 act as 256.
  assign cols_c = (cols_q[SCW-1] && (cols_q[SCW-2:0] != '0)) ? SCW'(256) : cols_q;
  assign rows_c = (rows_q[SCW-1] && (rows_q[SCW-2:0] != '0)) ? SCW'(256) : rows_q;

  // Valid bits follow the items down the pipeline.
  logic [LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start_i && !busy_o};
    end
  end

  // Trig lookups
  logic signed [TW-1:0] ct, st, cp, sp, ca, sa, cb, sb;

  tpr_trig_rom u_rom_st (.clk_i, .angle_i(theta_angle_i), .sine_o(st));
  tpr_trig_rom u_rom_ct (.clk_i, .angle_i(theta_angle_i + A'(tpr_pkg::QUARTER)), .sine_o(ct));
  tpr_trig_rom u_rom_sp (.clk_i, .angle_i(phi_angle_i), .sine_o(sp));
  tpr_trig_rom u_rom_cp (.clk_i, .angle_i(phi_angle_i + A'(tpr_pkg::QUARTER)), .sine_o(cp));
  tpr_trig_rom u_rom_sa (.clk_i, .angle_i(angle_a_q), .sine_o(sa));
  tpr_trig_rom u_rom_ca (.clk_i, .angle_i(angle_a_q + A'(tpr_pkg::QUARTER)), .sine_o(ca));
  tpr_trig_rom u_rom_sb (.clk_i, .angle_i(angle_b_q), .sine_o(sb));
  tpr_trig_rom u_rom_cb (.clk_i, .angle_i(angle_b_q + A'(tpr_pkg::QUARTER)), .sine_o(cb));

  logic signed [VW-1:0]           x2, y2, dep;
  logic [tpr_pkg::SHADE_W-1:0]    shade5;

  tpr_geom u_geom (
    .clk_i,
    .ct_i(ct), .st_i(st), .cp_i(cp), .sp_i(sp),
    .ca_i(ca), .sa_i(sa), .cb_i(cb), .sb_i(sb),
    .major_i(major_q), .minor_i(minor_q), .vd_i(vd_q),
    .x2_o(x2), .y2_o(y2), .d_o(dep), .shade_o(shade5)
  );

  // Numerators of (30 x + 40 d) / d and (15 y + 12 d) / d.
  logic signed [NUMW-1:0]        nx_q, ny_q;
  logic [tpr_pkg::DMAG_W-1:0]    den_q;
  logic                          dpos6_q;
  logic [tpr_pkg::SHADE_W-1:0]   shade6_q;

  always_ff @(posedge clk_i) begin
    nx_q     <= NUMW'(x2) * NUMW'(30) + NUMW'(dep) * NUMW'(40);
    ny_q     <= NUMW'(y2) * NUMW'(15) + NUMW'(dep) * NUMW'(12);
    den_q    <= dep[tpr_pkg::DMAG_W-1:0];
    dpos6_q  <= !dep[VW-1] && (dep != '0);
    shade6_q <= shade5;
  end

  logic [tpr_pkg::Q_BITS-1:0] qx, qy;
  logic                       bigx, bigy, negx, negy;

  tpr_div u_div_x (.clk_i, .num_i(nx_q), .den_i(den_q), .quot_o(qx), .big_o(bigx), .neg_o(negx));
  tpr_div u_div_y (.clk_i, .num_i(ny_q), .den_i(den_q), .quot_o(qy), .big_o(bigy), .neg_o(negy));

  logic                         dpos_q  [SIDE];
  logic [tpr_pkg::SHADE_W-1:0]  shade_q [SIDE];

  always_ff @(posedge clk_i) begin
    dpos_q[0]  <= dpos6_q;
    shade_q[0] <= shade6_q;
    for (int i = 1; i < SIDE; i++) begin
      dpos_q[i]  <= dpos_q[i-1];
      shade_q[i] <= shade_q[i-1];
    end
  end

  // A negative quotient is on screen only when it truncates to zero.
  logic ok_x, ok_y, vis;

  assign ok_x = !bigx && (qx < cols_c) && (!negx || (qx == '0));
  assign ok_y = !bigy && (qy < rows_c) && (!negy || (qy == '0));
  assign vis  = dpos_q[SIDE-1] && ok_x && ok_y;

  logic [tpr_pkg::CELL_W-1:0]  cell_x_q, cell_y_q;
  logic [tpr_pkg::SHADE_W-1:0] shade_out_q;
  logic                        on_q;

  always_ff @(posedge clk_i) begin
    cell_x_q    <= vis ? qx[tpr_pkg::CELL_W-1:0] : '0;
    cell_y_q    <= vis ? qy[tpr_pkg::CELL_W-1:0] : '0;
    shade_out_q <= shade_q[SIDE-1];
    on_q        <= vis;
  end

  assign done_o        = vld_q[LAT-1];
  assign cell_x_o      = cell_x_q;
  assign cell_y_o      = cell_y_q;
  assign shade_index_o = shade_out_q;
  assign on_screen_o   = on_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##11 done_o)
    else $error("item did not complete after the pipeline latency");

  a_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && on_screen_o |-> ({1'b0, cell_x_o} < cols_c) && ({1'b0, cell_y_o} < rows_c))
    else $error("visible cell outside the screen");

  a_offzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !on_screen_o |-> (cell_x_o == '0) && (cell_y_o == '0))
    else $error("off-screen item carries a nonzero cell");

  a_shade: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (shade_index_o <= tpr_pkg::SHADE_W'(11)))
    else $error("shade index out of range");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the torus point renderer: directed, config sweeps and random points.
module testbench;
  import tpr_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [CELL_W-1:0]  cell_x;
    logic [CELL_W-1:0]  cell_y;
    logic [SHADE_W-1:0] shade;
    logic               on_screen;
  } cell_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [ANGLE_BITS-1:0] theta_angle_i = '0;
  logic [ANGLE_BITS-1:0] phi_angle_i = '0;
  logic cfg_valid_i = 1'b0;
  logic [2:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic busy_o, cfg_ready_o, done_o, on_screen_o;
  logic [CELL_W-1:0] cell_x_o, cell_y_o;
  logic [SHADE_W-1:0] shade_index_o;

  torus_point_render uut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the configuration registers.
  int unsigned rot_x_code = 0, rot_z_code = 0;
  longint ring_rad = 8192, tube_rad = 4096, view_dist = 20480;
  longint cols_reg = 80, rows_reg = 22;

  cell_result_t pending_cells[$];
  int mismatch_count = 0;
  int sender_idle_pct = 0;
  int cycle_count = 0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  function automatic longint table_sine(input int unsigned code);
    int unsigned a, quad, r;
    longint unsigned x, x2, t, s, v;
    longint unsigned den [5] = '{110, 72, 42, 20, 6};
    a = code & ((1 << ANGLE_BITS) - 1);
    quad = a >> (ANGLE_BITS - 2);
    r = a & (QUARTER - 1);
    if (quad[0]) r = QUARTER - r;
    x = (longint'(r) * 64'd1686629713) >> (ANGLE_BITS - 2);
    x2 = (x * x) >> 30;
    t = 64'd1 << 30;
    for (int i = 0; i < 5; i++) t = (64'd1 << 30) - ((x2 * t) >> 30) / den[i];
    s = (x * t) >> 30;
    v = (s + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    return (quad >= 2) ? -longint'(v) : longint'(v);
  endfunction

  function automatic longint table_cosine(input int unsigned code);
    return table_sine(code + QUARTER);
  endfunction

  // Arithmetic shift of the signed product floors it.
  function automatic longint qmul(input longint a, input longint b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  function automatic cell_result_t project_point(input int unsigned theta, input int unsigned phi);
    cell_result_t res;
    longint ct, st, cp, sp, ca, sa, cb, sb;
    longint w, x, y, z, y1, z1, x2, y2, d, n, px, py, cols, rows;
    longint unsigned nn, oo;
    ct = table_cosine(theta); st = table_sine(theta);
    cp = table_cosine(phi);   sp = table_sine(phi);
    ca = table_cosine(rot_x_code); sa = table_sine(rot_x_code);
    cb = table_cosine(rot_z_code); sb = table_sine(rot_z_code);
    w = ring_rad + qmul(tube_rad, ct);
    x = qmul(w, cp);
    y = qmul(w, sp);
    z = qmul(tube_rad, st);
    y1 = qmul(y, ca) - qmul(z, sa);
    z1 = qmul(y, sa) + qmul(z, ca);
    x2 = qmul(x, cb) - qmul(y1, sb);
    y2 = qmul(x, sb) + qmul(y1, cb);
    d = z1 + view_dist;
    cols = (cols_reg > 256) ? 256 : cols_reg;
    rows = (rows_reg > 256) ? 256 : rows_reg;
    res = '0;
    if (d > 0) begin
      px = (30 * x2 + 40 * d) / d;
      py = (15 * y2 + 12 * d) / d;
      if (px >= 0 && px < cols && py >= 0 && py < rows) begin
        res.on_screen = 1'b1;
        res.cell_x = px[CELL_W-1:0];
        res.cell_y = py[CELL_W-1:0];
      end
    end
    n = qmul(ct, sp) - st;
    if (n > 0) begin
      nn = longint'(n) * longint'(n) * 121;
      oo = 64'd2 << (2 * FRAC_BITS);
      for (int k = 1; k <= 11; k++) if (longint'(k * k) * oo <= nn) res.shade = SHADE_W'(k);
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("torus_point_render test failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    cell_result_t want;
    if (rst_ni && done_o) begin
      if (pending_cells.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        want = pending_cells.pop_front();
        if (cell_x_o !== want.cell_x)
          report_mismatch($sformatf("cell_x %0d, want %0d", cell_x_o, want.cell_x));
        if (cell_y_o !== want.cell_y)
          report_mismatch($sformatf("cell_y %0d, want %0d", cell_y_o, want.cell_y));
        if (shade_index_o !== want.shade)
          report_mismatch($sformatf("shade %0d, want %0d", shade_index_o, want.shade));
        if (on_screen_o !== want.on_screen)
          report_mismatch($sformatf("on_screen %0b, want %0b", on_screen_o, want.on_screen));
      end
    end
  end

  // Leaves start_i high so back-to-back items need no second assignment in one step.
  task automatic send_point(input int unsigned theta, input int unsigned phi);
    while ($urandom_range(99) < sender_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    theta_angle_i <= theta[ANGLE_BITS-1:0];
    phi_angle_i <= phi[ANGLE_BITS-1:0];
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_cells.push_back(project_point(theta & 12'hFFF, phi & 12'hFFF));
  endtask

  task automatic drain;
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_cells.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int unsigned value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value[CFG_W-1:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_ANGLE_A:       rot_x_code = value & 12'hFFF;
      REG_ANGLE_B:       rot_z_code = value & 12'hFFF;
      REG_MAJOR_RADIUS:  ring_rad = value & 16'h7FFF;
      REG_MINOR_RADIUS:  tube_rad = value & 16'h7FFF;
      REG_VIEW_DISTANCE: view_dist = value & 16'hFFFF;
      REG_SCREEN_COLS:   cols_reg = value & 9'h1FF;
      REG_SCREEN_ROWS:   rows_reg = value & 9'h1FF;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_view(input int unsigned ax, input int unsigned bz, input int unsigned ring,
                          input int unsigned tube, input int unsigned vd,
                          input int unsigned cols, input int unsigned rows);
    write_reg(REG_ANGLE_A, ax);
    write_reg(REG_ANGLE_B, bz);
    write_reg(REG_MAJOR_RADIUS, ring);
    write_reg(REG_MINOR_RADIUS, tube);
    write_reg(REG_VIEW_DISTANCE, vd);
    write_reg(REG_SCREEN_COLS, cols);
    write_reg(REG_SCREEN_ROWS, rows);
  endtask

  task automatic test_directed_points;
    int unsigned codes [6] = '{0, 1, 1024, 2048, 3072, 4095};
    foreach (codes[i]) begin
      send_point(codes[i], codes[(i + 2) % 6]);
      send_point(codes[i], codes[i]);
    end
    drain();
    // Small negative projections land in column 0 when the screen starts at -1.33.
    set_view(0, 0, 8192, 4096, 20480, 80, 22);
    send_point(2048, 2048);
    send_point(1024, 3072);
    drain();
  endtask

  task automatic test_register_extremes;
    // The viewer sits at zero, so depth is the rotated z alone and can take either sign.
    set_view(4095, 4095, 32767, 32767, 0, 256, 256);
    for (int i = 0; i < 4; i++) send_point($urandom, $urandom);
    drain();
    set_view(1024, 2048, 0, 0, 65535, 0, 0);
    send_point(0, 0);
    send_point(4095, 4095);
    drain();
    // Sizes above 256 clamp to 256; an unknown register index has no effect.
    set_view(512, 3000, 4096, 2048, 8192, 511, 300);
    write_reg(REG_UNUSED, 16'hFFFF);
    for (int i = 0; i < 4; i++) send_point($urandom, $urandom);
    drain();
    set_view(0, 0, 8192, 4096, 20480, 1, 1);
    send_point(0, 1024);
    send_point(3072, 0);
    drain();
  endtask

  task automatic test_random_points(input int idle_pct, input int count);
    sender_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 80 == 0) begin
        drain();
        if ($urandom_range(3) == 0)
          set_view($urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom_range(511), $urandom_range(511));
        else
          set_view($urandom, $urandom, $urandom_range(4096, 12288),
                   $urandom_range(1024, 6144), $urandom_range(12288, 40960),
                   $urandom_range(40, 256), $urandom_range(12, 256));
      end
      send_point($urandom, $urandom);
    end
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_points();
    test_register_extremes();
    test_random_points(21, 240);
    test_random_points(54, 240);
    test_random_points(0, 240);
    drain();
    if (mismatch_count == 0 && pending_cells.size() == 0) begin
      $display("torus_point_render test passed");
    end else begin
      $display("torus_point_render test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tpr_pkg.sv
rtl/core/tpr_trig_rom.sv
rtl/core/tpr_geom.sv
rtl/core/tpr_div.sv
rtl/core/torus_point_render.sv
tb/sv/testbench.sv
